[sv/mp3_frame_sync_header_decode_unit_assert.svh]
// Assertion macros for the MPEG audio frame sync and header decode unit.
// Included by the top level only; no other dependencies.
`ifndef MP3_FRAME_SYNC_HEADER_DECODE_UNIT_ASSERT_SVH
`define MP3_FRAME_SYNC_HEADER_DECODE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MP3FS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mp3fs same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MP3FS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mp3fs next-cycle check failed");

`endif

[sv/mp3fs_pkg.sv]
// Shared types, header constants and rate tables for the MPEG audio sync unit.
// No dependencies.
package mp3fs_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] offset;
    logic [1:0]  version;
    logic        crc_absent;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic        padding;
    logic [1:0]  chan_mode;
    logic [1:0]  mode_ext;
    logic [2:0]  marker_bits;
    logic [1:0]  emphasis;
    logic [10:0] frame_len;
  } out_item_t;

  // Status of the queue between the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_OUT
  } bk_state_t;

  localparam logic [7:0] SYNC_BYTE      = 8'hFF;
  localparam logic [7:0] SYNC_MASK      = 8'hE0;
  localparam logic [1:0] VBITS_RESERVED = 2'b01;
  localparam logic [1:0] VBITS_MPEG1    = 2'b11;
  localparam logic [1:0] VBITS_MPEG2    = 2'b10;
  localparam logic [1:0] LAYER_III      = 2'b01;
  localparam logic [3:0] BIDX_FREE      = 4'd0;
  localparam logic [3:0] BIDX_BAD       = 4'd15;
  localparam logic [1:0] SIDX_RESERVED  = 2'd3;

  localparam logic [1:0] VER_MPEG1  = 2'd0;
  localparam logic [1:0] VER_MPEG2  = 2'd1;
  localparam logic [1:0] VER_MPEG25 = 2'd2;

  // Bytes per frame times sample rate over bit rate in kbps.
  localparam logic [17:0] MULT_V1 = 18'd144000;
  localparam logic [17:0] MULT_V2 = 18'd72000;

  localparam int DIV_STEPS = 11;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int NUM_W     = 26;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  function automatic logic [8:0] rate_kbps(input logic [1:0] ver, input logic [3:0] bidx);
    logic [8:0] r;
    r = 9'd0;
    if (ver == VER_MPEG1) begin
      case (bidx)
        4'd1:    r = 9'd32;
        4'd2:    r = 9'd40;
        4'd3:    r = 9'd48;
        4'd4:    r = 9'd56;
        4'd5:    r = 9'd64;
        4'd6:    r = 9'd80;
        4'd7:    r = 9'd96;
        4'd8:    r = 9'd112;
        4'd9:    r = 9'd128;
        4'd10:   r = 9'd160;
        4'd11:   r = 9'd192;
        4'd12:   r = 9'd224;
        4'd13:   r = 9'd256;
        4'd14:   r = 9'd320;
        default: r = 9'd0;
      endcase
    end else begin
      case (bidx)
        4'd1:    r = 9'd8;
        4'd2:    r = 9'd16;
        4'd3:    r = 9'd24;
        4'd4:    r = 9'd32;
        4'd5:    r = 9'd40;
        4'd6:    r = 9'd48;
        4'd7:    r = 9'd56;
        4'd8:    r = 9'd64;
        4'd9:    r = 9'd80;
        4'd10:   r = 9'd96;
        4'd11:   r = 9'd112;
        4'd12:   r = 9'd128;
        4'd13:   r = 9'd144;
        4'd14:   r = 9'd160;
        default: r = 9'd0;
      endcase
    end
    return r;
  endfunction

  function automatic logic [15:0] rate_hz(input logic [1:0] ver, input logic [1:0] sidx);
    logic [15:0] r;
    case ({ver, sidx})
      {VER_MPEG1, 2'd0}:  r = 16'd44100;
      {VER_MPEG1, 2'd1}:  r = 16'd48000;
      {VER_MPEG1, 2'd2}:  r = 16'd32000;
      {VER_MPEG2, 2'd0}:  r = 16'd22050;
      {VER_MPEG2, 2'd1}:  r = 16'd24000;
      {VER_MPEG2, 2'd2}:  r = 16'd16000;
      {VER_MPEG25, 2'd0}: r = 16'd11025;
      {VER_MPEG25, 2'd1}: r = 16'd12000;
      {VER_MPEG25, 2'd2}: r = 16'd8000;
      default:            r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

[sv/mp3fs_front.sv]
// Front part: byte history, byte count and header window check.
// Depends on mp3fs_pkg; pushes one record per result into the queue.
module mp3fs_front #(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mp3fs_pkg::in_item_t in_data,
  input  mp3fs_pkg::q_stat_t  q_stat,
  output logic                push,
  output mp3fs_pkg::out_item_t push_data
);
  import mp3fs_pkg::*;

  logic [23:0]             hist_r, hist_nxt;
  logic [OFFSET_WIDTH-1:0] count_r, count_nxt;
  logic                    seen_r, seen_nxt;

  logic [7:0]              h0, h1, h2, h3;
  logic [1:0]              vbits, ver;
  logic [3:0]              bidx;
  logic [1:0]              sidx;
  logic                    hdr_ok, window_on, match, push_cond, accept;
  logic [OFFSET_WIDTH-1:0] off_w;
  logic [31:0]             off_ext;

  always_comb begin
    h0    = hist_r[23:16];
    h1    = hist_r[15:8];
    h2    = hist_r[7:0];
    h3    = in_data.data_byte;
    vbits = h1[4:3];
    bidx  = h2[7:4];
    sidx  = h2[3:2];
    case (vbits)
      VBITS_MPEG1: ver = VER_MPEG1;
      VBITS_MPEG2: ver = VER_MPEG2;
      default:     ver = VER_MPEG25;
    endcase
    // Frame size is never below four bytes for any legal header, so that
    // check needs no term here.
    hdr_ok = (h0 == SYNC_BYTE) && ((h1 & SYNC_MASK) == SYNC_MASK) &&
             (vbits != VBITS_RESERVED) && (h1[2:1] == LAYER_III) &&
             (bidx != BIDX_FREE) && (bidx != BIDX_BAD) && (sidx != SIDX_RESERVED);
    window_on = !seen_r && (count_r >= OFFSET_WIDTH'(3)) && (count_r != '1);
    match     = window_on && hdr_ok;
    push_cond = match || (in_data.last_byte && !seen_r);
    in_ready  = !q_stat.full || !push_cond;
    accept    = in_valid && in_ready;
    push      = accept && push_cond;

    off_w   = count_r - OFFSET_WIDTH'(3);
    off_ext = 32'(off_w);

    push_data = '0;
    if (match) begin
      push_data.found          = 1'b1;
      push_data.offset         = off_ext[15:0];
      push_data.version        = ver;
      push_data.crc_absent     = h1[0];
      push_data.bitrate_kbps   = rate_kbps(ver, bidx);
      push_data.sample_rate_hz = rate_hz(ver, sidx);
      push_data.padding        = h2[1];
      push_data.chan_mode      = h3[7:6];
      push_data.mode_ext       = h3[5:4];
      push_data.marker_bits    = {h2[0], h3[3], h3[2]};
      push_data.emphasis       = h3[1:0];
    end

    hist_nxt  = hist_r;
    count_nxt = count_r;
    seen_nxt  = seen_r;
    if (accept) begin
      if (in_data.last_byte) begin
        hist_nxt  = '0;
        count_nxt = '0;
        seen_nxt  = 1'b0;
      end else begin
        hist_nxt = {hist_r[15:0], in_data.data_byte};
        if (count_r != '1) begin
          count_nxt = count_r + OFFSET_WIDTH'(1);
        end
        seen_nxt = seen_r || match;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r  <= '0;
      count_r <= '0;
      seen_r  <= 1'b0;
    end else begin
      hist_r  <= hist_nxt;
      count_r <= count_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

[sv/mp3fs_queue.sv]
// Two-entry queue of result records between the front and back parts.
// Depends on mp3fs_pkg.
module mp3fs_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mp3fs_pkg::out_item_t push_data,
  input  logic                 pop,
  output mp3fs_pkg::q_stat_t   q_stat,
  output mp3fs_pkg::out_item_t head
);
  import mp3fs_pkg::*;

  out_item_t          mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  always_comb begin
    q_stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
    q_stat.empty = (cnt_r == '0);
    head         = mem_r[rd_r];
    do_push      = push && !q_stat.full;
    do_pop       = pop && !q_stat.empty;
    wr_nxt       = do_push ? wr_r + Q_PTR_W'(1) : wr_r;
    rd_nxt       = do_pop ? rd_r + Q_PTR_W'(1) : rd_r;
    cnt_nxt      = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[sv/mp3fs_back.sv]
// Back part: frame size by multiply and restoring division, and output register.
// Depends on mp3fs_pkg; pops records from mp3fs_queue.
module mp3fs_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mp3fs_pkg::q_stat_t   q_stat,
  input  mp3fs_pkg::out_item_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mp3fs_pkg::out_item_t out_data
);
  import mp3fs_pkg::*;

  bk_state_t        state_r, state_nxt;
  out_item_t        item_r, item_nxt;
  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [10:0]      quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [17:0]      mult;
  logic [26:0]      prod;
  logic [NUM_W:0]   div_shift, trial;
  logic [10:0]      quo_new;

  always_comb begin
    mult      = (item_r.version == VER_MPEG1) ? MULT_V1 : MULT_V2;
    prod      = {18'd0, item_r.bitrate_kbps} * {9'd0, mult};
    div_shift = (NUM_W + 1)'(item_r.sample_rate_hz) << cnt_r;
    trial     = {1'b0, rem_r} - div_shift;
    quo_new   = {quo_r[9:0], !trial[NUM_W]};

    state_nxt = state_r;
    item_nxt  = item_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    pop       = 1'b0;
    out_valid = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          item_nxt  = head;
          state_nxt = head.found ? BK_MUL : BK_OUT;
        end
      end
      BK_MUL: begin
        rem_nxt   = prod[NUM_W-1:0];
        quo_nxt   = '0;
        cnt_nxt   = CNT_W'(DIV_STEPS - 1);
        state_nxt = BK_DIV;
      end
      BK_DIV: begin
        // One quotient bit per cycle, most significant first.
        if (!trial[NUM_W]) begin
          rem_nxt = trial[NUM_W-1:0];
        end
        quo_nxt = quo_new;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          item_nxt.frame_len = quo_new + {10'd0, item_r.padding};
          state_nxt          = BK_OUT;
        end
      end
      BK_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase

    out_data = item_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule

[sv/mp3_frame_sync_header_decode_unit.sv]
// Channel  Handshake             Payload
// in       in_valid / in_ready   in_data   (mp3fs_pkg::in_item_t, one byte and last mark)
// out      out_valid / out_ready out_data  (mp3fs_pkg::out_item_t, sync result)
//
// The front takes one byte per cycle and stalls only when a result must be queued and
// the two-entry queue is full. A result without a header passes the back through pop and
// output only; a found header passes through pop, one multiply, 11 divider steps and output.
// Reset is synchronous on rst_n low and clears history, count, queue and back state.
// A stalled output holds the back, and the queue then absorbs up to two more results.
// Top level of the MPEG audio frame sync and header decode unit.
// Depends on mp3fs_pkg, mp3fs_front, mp3fs_queue, mp3fs_back and the assertion header.
module mp3_frame_sync_header_decode_unit #(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mp3fs_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mp3fs_pkg::out_item_t out_data
);
  import mp3fs_pkg::*;

  `include "mp3_frame_sync_header_decode_unit_assert.svh"

  q_stat_t   q_stat;
  logic      push, pop;
  out_item_t push_data, head;

  mp3fs_front #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_data(push_data)
  );

  mp3fs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .q_stat   (q_stat),
    .head     (head)
  );

  mp3fs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // A record is never offered to a full queue.
  `MP3FS_ASSERT_NOW(a_no_overflow, clk, rst_n, push, !q_stat.full)

  // A found header always reports a legal version, a rate and a real frame.
  `MP3FS_ASSERT_NOW(a_found_legal, clk, rst_n, out_valid && out_data.found,
    (out_data.version <= VER_MPEG25) && (out_data.bitrate_kbps != 9'd0) &&
    (out_data.frame_len >= 11'd4))

  // A pushed record leaves the queue non-empty in the next cycle.
  `MP3FS_ASSERT_NEXT(a_push_lands, clk, rst_n, push && !pop, !q_stat.empty)

endmodule

[verif/mp3fs_sync_checker.sv]
// Checker for the MPEG audio frame sync unit: watches both channels, predicts each
// result from the accepted bytes and compares field by field. Depends on mp3fs_pkg.
module mp3fs_sync_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  mp3fs_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  mp3fs_pkg::out_item_t out_data,
  output int                   errors,
  output int                   owed,
  output int                   results,
  output int                   headers
);
  import mp3fs_pkg::*;

  localparam logic [15:0] COUNT_LIMIT = 16'hFFFF;

  logic [23:0] prev_bytes;
  logic [15:0] pos_count;
  logic        header_reported;
  out_item_t   pending_results[$];
  out_item_t   want;
  out_item_t   hdr;

  // Decodes one 4-byte window; returns 0 when it is not a usable Layer III header.
  function automatic logic decode_window(input logic [7:0] h0, input logic [7:0] h1,
                                         input logic [7:0] h2, input logic [7:0] h3,
                                         output out_item_t r);
    logic [1:0]  vbits;
    logic [1:0]  ver;
    logic [1:0]  sidx;
    logic [3:0]  bidx;
    logic        mpeg1;
    int unsigned kbps;
    int unsigned hz;
    int unsigned fsize;
    r = '0;
    if (h0 != SYNC_BYTE || (h1 & SYNC_MASK) != SYNC_MASK) return 1'b0;
    vbits = h1[4:3];
    if (vbits == VBITS_RESERVED || h1[2:1] != LAYER_III) return 1'b0;
    bidx = h2[7:4];
    sidx = h2[3:2];
    if (bidx == BIDX_FREE || bidx == BIDX_BAD || sidx == SIDX_RESERVED) return 1'b0;
    ver = (vbits == VBITS_MPEG1) ? VER_MPEG1 : (vbits == VBITS_MPEG2) ? VER_MPEG2 : VER_MPEG25;
    mpeg1 = (ver == VER_MPEG1);
    case (bidx)
      4'd1:    kbps = mpeg1 ? 32  : 8;
      4'd2:    kbps = mpeg1 ? 40  : 16;
      4'd3:    kbps = mpeg1 ? 48  : 24;
      4'd4:    kbps = mpeg1 ? 56  : 32;
      4'd5:    kbps = mpeg1 ? 64  : 40;
      4'd6:    kbps = mpeg1 ? 80  : 48;
      4'd7:    kbps = mpeg1 ? 96  : 56;
      4'd8:    kbps = mpeg1 ? 112 : 64;
      4'd9:    kbps = mpeg1 ? 128 : 80;
      4'd10:   kbps = mpeg1 ? 160 : 96;
      4'd11:   kbps = mpeg1 ? 192 : 112;
      4'd12:   kbps = mpeg1 ? 224 : 128;
      4'd13:   kbps = mpeg1 ? 256 : 144;
      default: kbps = mpeg1 ? 320 : 160;
    endcase
    case (sidx)
      2'd0:    hz = 44100;
      2'd1:    hz = 48000;
      default: hz = 32000;
    endcase
    // MPEG-2 halves the MPEG-1 rates and MPEG-2.5 quarters them.
    if (ver == VER_MPEG2) hz = hz / 2;
    else if (ver == VER_MPEG25) hz = hz / 4;
    fsize = ((mpeg1 ? 144 : 72) * kbps * 1000) / hz + 32'(h2[1]);
    if (fsize < 4) return 1'b0;
    r.version        = ver;
    r.crc_absent     = h1[0];
    r.bitrate_kbps   = kbps[8:0];
    r.sample_rate_hz = hz[15:0];
    r.padding        = h2[1];
    r.chan_mode      = h3[7:6];
    r.mode_ext       = h3[5:4];
    r.marker_bits    = {h2[0], h3[3], h3[2]};
    r.emphasis       = h3[1:0];
    r.frame_len      = fsize[10:0];
    return 1'b1;
  endfunction

  task automatic check_field(input string field, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      prev_bytes = '0;
      pos_count = '0;
      header_reported = 1'b0;
      pending_results.delete();
      owed = 0;
    end else begin
      if (out_valid && out_ready) begin
        results++;
        if (out_data.found) headers++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: expected no result, got %p", $time, out_data);
        end else begin
          want = pending_results.pop_front();
          check_field("found", 32'(want.found), 32'(out_data.found));
          check_field("offset", 32'(want.offset), 32'(out_data.offset));
          check_field("version", 32'(want.version), 32'(out_data.version));
          check_field("crc_absent", 32'(want.crc_absent), 32'(out_data.crc_absent));
          check_field("bitrate_kbps", 32'(want.bitrate_kbps),
                      32'(out_data.bitrate_kbps));
          check_field("sample_rate_hz", 32'(want.sample_rate_hz),
                      32'(out_data.sample_rate_hz));
          check_field("padding", 32'(want.padding), 32'(out_data.padding));
          check_field("chan_mode", 32'(want.chan_mode), 32'(out_data.chan_mode));
          check_field("mode_ext", 32'(want.mode_ext), 32'(out_data.mode_ext));
          check_field("marker_bits", 32'(want.marker_bits), 32'(out_data.marker_bits));
          check_field("emphasis", 32'(want.emphasis), 32'(out_data.emphasis));
          check_field("frame_len", 32'(want.frame_len), 32'(out_data.frame_len));
        end
      end
      if (in_valid && in_ready) begin
        // Only the first header of a buffer is reported, and only at searchable offsets.
        if (!header_reported && pos_count >= 16'd3 && pos_count < COUNT_LIMIT) begin
          if (decode_window(prev_bytes[23:16], prev_bytes[15:8], prev_bytes[7:0],
                            in_data.data_byte, hdr)) begin
            hdr.found = 1'b1;
            hdr.offset = pos_count - 16'd3;
            pending_results.push_back(hdr);
            header_reported = 1'b1;
          end
        end
        if (in_data.last_byte) begin
          if (!header_reported) pending_results.push_back('0);
          prev_bytes = '0;
          pos_count = '0;
          header_reported = 1'b0;
        end else begin
          prev_bytes = {prev_bytes[15:0], in_data.data_byte};
          if (pos_count != COUNT_LIMIT) pos_count++;
        end
      end
      owed = pending_results.size();
    end
  end

endmodule

[verif/mp3_frame_sync_header_decode_unit_tb.sv]
// Testbench top for the MPEG audio frame sync unit: drives byte buffers and result stalls,
// and gives the verdict. Depends on mp3fs_pkg, the unit and mp3fs_sync_checker.
module mp3_frame_sync_header_decode_unit_tb;
  import mp3fs_pkg::*;

  localparam logic [1:0] VBITS_MPEG25 = 2'b00;
  localparam int         GAP_MAX      = 11;
  localparam int         RANDOM_BYTES = 1900;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        errors;
  int        owed;
  int        results;
  int        headers;
  int        bytes_sent = 0;
  int        buffers_sent = 0;
  logic [7:0] pkt_bytes[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mp3_frame_sync_header_decode_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  mp3fs_sync_checker sync_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .errors    (errors),
    .owed      (owed),
    .results   (results),
    .headers   (headers)
  );

  // Valid stays high across back-to-back items; it drops only when a gap is drawn.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {b, last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_buffer();
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    end
    buffers_sent++;
  endtask

  initial begin : results_side
    int stall;
    forever begin
      stall = $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  initial begin : stimulus
    int         len;
    int         nhdr;
    int         pos;
    int         random_bytes;
    logic [7:0] h0;
    logic [2:0] sync_bits;
    logic [1:0] vbits;
    logic [1:0] layer;
    logic [3:0] bidx;
    logic [1:0] sidx;
    random_bytes = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // A buffer too short to hold any window.
    pkt_bytes = {8'hFF};
    send_buffer();
    // Three header bytes and then the end: still no complete window.
    pkt_bytes = {8'hFF, 8'hFB, 8'h90};
    send_buffer();
    // MPEG-1 at 320 kbps, 48 kHz, padded, all of the last byte set; found on the last byte.
    pkt_bytes = {8'hFF, 8'hFA, 8'hE6, 8'hFF};
    send_buffer();
    // MPEG-2.5 at 8 kbps, 8 kHz, then a second valid header that must stay silent.
    pkt_bytes = {8'hFF, 8'hE3, 8'h19, 8'h00, 8'hFF, 8'hFB, 8'h90, 8'hC4};
    send_buffer();
    // Free-format and bad bitrate indexes (the bad one with a reserved rate index), so nothing is found.
    pkt_bytes = {8'hFF, 8'hF3, 8'h0C, 8'hFF, 8'hFB, 8'hFC, 8'h00};
    send_buffer();

    // Mostly buffers carrying well-formed headers in noise, some with a broken field.
    while (random_bytes < RANDOM_BYTES) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
      pkt_bytes.delete();
      for (int i = 0; i < len; i++) begin
        pkt_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom));
      end
      nhdr = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 2);
      for (int k = 0; k < nhdr && len >= 4; k++) begin
        h0 = SYNC_BYTE;
        sync_bits = 3'b111;
        case ($urandom_range(0, 2))
          0:       vbits = VBITS_MPEG1;
          1:       vbits = VBITS_MPEG2;
          default: vbits = VBITS_MPEG25;
        endcase
        layer = LAYER_III;
        bidx = 4'($urandom_range(1, 14));
        sidx = 2'($urandom_range(0, 2));
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 5))
            0:       h0 = 8'($urandom_range(0, 254));
            1:       sync_bits[2'($urandom_range(0, 2))] = 1'b0;
            2:       vbits = VBITS_RESERVED;
            3:       layer = LAYER_III ^ 2'($urandom_range(1, 3));
            4:       bidx = $urandom_range(0, 1) ? BIDX_BAD : BIDX_FREE;
            default: sidx = SIDX_RESERVED;
          endcase
        end
        pos = $urandom_range(0, len - 4);
        pkt_bytes[pos] = h0;
        pkt_bytes[pos + 1] = {sync_bits, vbits, layer, 1'($urandom)};
        pkt_bytes[pos + 2] = {bidx, sidx, 2'($urandom)};
        pkt_bytes[pos + 3] = 8'($urandom);
      end
      send_buffer();
      random_bytes += len;
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (owed != 0);
    repeat (40) @(posedge clk);
    @(negedge clk);
    $display("Sent %0d bytes in %0d buffers, from too-short ones to noisy multi-header ones.",
             bytes_sent, buffers_sent);
    $display("Checked %0d results, %0d of them reporting a header.", results, headers);
    if (errors == 0) begin
      $display("mp3_frame_sync_header_decode_unit_tb passed");
    end else begin
      $display("mp3_frame_sync_header_decode_unit_tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #6_000_000;
    $display("mp3_frame_sync_header_decode_unit_tb failed");
    $finish;
  end

endmodule
